FILE: hdl/lert_pkg.sv
`default_nettype none
package lert_pkg;

    // default store depth
    localparam int DEF_MAX_LENGTH = 1024;

    // fixed field widths
    localparam int CHAR_W = 8;
    localparam int POS_W  = 10;
    localparam int LEN_W  = 11;

    // request kinds carried in s_tuser
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_REPORT = 1'b1;

    // reset value of the length register
    localparam logic [LEN_W-1:0] ACTIVE_LENGTH_RESET = 11'd1024;

endpackage
`default_nettype wire

FILE: hdl/lert_merge.sv
`default_nettype none
module lert_merge
    import lert_pkg::*;
#(
    parameter int RW = 11
)
(
    input  wire logic [4*RW+2*CHAR_W-1:0] left,
    input  wire logic [4*RW+2*CHAR_W-1:0] right,
    output logic      [4*RW+2*CHAR_W-1:0] parent
);

    logic [RW-1:0]     cnt_l, pre_l, suf_l, best_l;
    logic [RW-1:0]     cnt_r, pre_r, suf_r, best_r;
    logic [CHAR_W-1:0] first_l, last_l, first_r, last_r;
    logic [RW-1:0]     pre_p, suf_p, best_p, mid, best_lr;
    logic              join_ok;

    // unpack both children
    assign cnt_l   = left[RW-1:0];
    assign pre_l   = left[2*RW-1:RW];
    assign suf_l   = left[3*RW-1:2*RW];
    assign best_l  = left[4*RW-1:3*RW];
    assign first_l = left[4*RW+CHAR_W-1:4*RW];
    assign last_l  = left[4*RW+2*CHAR_W-1:4*RW+CHAR_W];
    assign cnt_r   = right[RW-1:0];
    assign pre_r   = right[2*RW-1:RW];
    assign suf_r   = right[3*RW-1:2*RW];
    assign best_r  = right[4*RW-1:3*RW];
    assign first_r = right[4*RW+CHAR_W-1:4*RW];
    assign last_r  = right[4*RW+2*CHAR_W-1:4*RW+CHAR_W];

    // runs join across the boundary when the edge characters match
    assign join_ok = (cnt_r != '0) && (cnt_l != '0) && (last_l == first_r);
    assign mid     = join_ok ? (suf_l + pre_r) : '0;
    assign best_lr = (best_l > best_r) ? best_l : best_r;

    always_comb
    begin
        pre_p  = (join_ok && (pre_l == cnt_l)) ? (cnt_l + pre_r) : pre_l;
        suf_p  = (join_ok && (suf_r == cnt_r)) ? (cnt_r + suf_l) : suf_r;
        best_p = (mid > best_lr) ? mid : best_lr;
        // absent positions only ever sit on the right
        if (cnt_r == '0)
        begin
            parent = left;
        end
        else
        begin
            parent = {last_r, first_l, best_p, suf_p, pre_p, cnt_l + cnt_r};
        end
    end

endmodule
`default_nettype wire

FILE: hdl/lert_node_ram.sv
`default_nettype none
module lert_node_ram
    import lert_pkg::*;
#(
    parameter int AW = 11,
    parameter int NW = 60
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [NW-1:0] wdata,
    input  wire logic [AW-1:0] raddr_a,
    input  wire logic [AW-1:0] raddr_b,
    output logic      [NW-1:0] rdata_a,
    output logic      [NW-1:0] rdata_b
);

    logic [NW-1:0] mem [2**AW];

    // one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire

FILE: hdl/longest_equal_run_tracker.sv
`default_nettype none
// Longest equal run tracker: each in-range request writes one character and, when
// s_tuser is set, reports the longest run of equal characters in the first
// active_length positions. The run summary lives in a binary tree held in a
// two-read-port node memory and is updated by one shared merge unit. A good
// write-and-report walks from leaf to root, reading and then writing each
// level after the accept, then enters the result state; a good silent load
// returns to idle from the root. A report at an out-of-range position goes
// straight to the result state and a silent load there ends on its accept.
// A report also waits while the previous result is still held unaccepted.
// After reset and after every write of active_length all 2*N-1 tree nodes
// are rebuilt, leaves first (clearing the store after reset), N being
// MAX_LENGTH rounded up to a power of two; no request is taken meanwhile.
module longest_equal_run_tracker
    import lert_pkg::*;
#(
    parameter int MAX_LENGTH = DEF_MAX_LENGTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // position[9:0], character[17:10]
    input  wire logic [0:0]  s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // longest_run[10:0]
    output logic      [0:0]  m_tuser    // bad_position
);

    localparam int LOG = $clog2(MAX_LENGTH);
    localparam int N   = 2**LOG;
    localparam int AW  = LOG + 1;
    localparam int RW  = LOG + 1;
    localparam int NW  = 4*RW + 2*CHAR_W;
    localparam int CW  = (LOG + 1 > LEN_W) ? LOG + 1 : LEN_W;
    localparam logic [CW-1:0] MAXC     = CW'(MAX_LENGTH);
    localparam logic [AW-1:0] TOP_NODE = AW'(2*N - 1);
    localparam logic [AW-1:0] LEAF0    = AW'(N);
    localparam logic [AW-1:0] ROOT     = AW'(1);

    localparam logic [2:0] S_LF_RD  = 3'd0;
    localparam logic [2:0] S_LF_WR  = 3'd1;
    localparam logic [2:0] S_INT_RD = 3'd2;
    localparam logic [2:0] S_INT_WR = 3'd3;
    localparam logic [2:0] S_IDLE   = 3'd4;
    localparam logic [2:0] S_UP_RD  = 3'd5;
    localparam logic [2:0] S_UP_WR  = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic              clear_reg, clear_next;
    logic              report_reg, report_next;
    logic              bad_reg, bad_next;
    logic [LEN_W-1:0]  active_reg;
    logic [RW-1:0]     root_best_reg;
    logic              m_valid_reg;
    logic [LEN_W-1:0]  m_run_reg;
    logic              m_bad_reg;
    logic [CHAR_W-1:0] char_rd_reg;
    logic [CHAR_W-1:0] char_mem [N];

    logic [POS_W-1:0]  in_pos;
    logic [CHAR_W-1:0] in_char;
    logic              in_report, accept, in_bad;
    logic [CW-1:0]     eff_len, pos_ext, leaf_ext;
    logic [LOG-1:0]    in_idx, leaf_idx;
    logic [LOG+POS_W-1:0] pos_wide;
    logic [RW+LEN_W-1:0] best_wide;
    logic              leaf_present;
    logic [CHAR_W-1:0] leaf_char;
    logic [NW-1:0]     leaf_node, in_leaf, merged, rdata_a, rdata_b;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, raddr_a, raddr_b;
    logic [NW-1:0]     ram_wdata;

    // request fields
    assign in_pos    = s_tdata[POS_W-1:0];
    assign in_char   = s_tdata[POS_W+CHAR_W-1:POS_W];
    assign in_report = (s_tuser[0] == REQ_REPORT);
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);

    // effective length and range check
    assign eff_len = ({{(CW-LEN_W){1'b0}}, active_reg} > MAXC) ? MAXC
                   : {{(CW-LEN_W){1'b0}}, active_reg};
    assign pos_wide = {{LOG{1'b0}}, in_pos};
    assign pos_ext  = {{(CW-POS_W){1'b0}}, in_pos};
    assign in_idx   = pos_wide[LOG-1:0];
    assign in_bad   = (pos_ext >= eff_len);

    // leaf built during a rebuild sweep
    assign leaf_idx     = idx_reg[LOG-1:0];
    assign leaf_ext     = {{(CW-LOG){1'b0}}, leaf_idx};
    assign leaf_present = (leaf_ext < eff_len);
    assign leaf_char    = clear_reg ? '0 : char_rd_reg;
    assign leaf_node    = leaf_present
                        ? {leaf_char, leaf_char, RW'(1), RW'(1), RW'(1), RW'(1)}
                        : '0;
    assign in_leaf      = {in_char, in_char, RW'(1), RW'(1), RW'(1), RW'(1)};

    // children of the current node
    assign raddr_a = {idx_reg[AW-2:0], 1'b0};
    assign raddr_b = {idx_reg[AW-2:0], 1'b1};

    lert_merge #(.RW(RW)) u_merge
    (
        .left   (rdata_a),
        .right  (rdata_b),
        .parent (merged)
    );

    lert_node_ram #(.AW(AW), .NW(NW)) u_ram
    (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // tree write port
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = merged;
        unique case (state_reg)
            S_LF_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = leaf_node;
            end
            S_INT_WR, S_UP_WR:
            begin
                ram_we = 1'b1;
            end
            S_IDLE:
            begin
                ram_we    = accept && !in_bad;
                ram_waddr = {1'b1, in_idx};
                ram_wdata = in_leaf;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // character store
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LF_RD)
        begin
            char_rd_reg <= char_mem[leaf_idx];
            if (clear_reg)
            begin
                char_mem[leaf_idx] <= '0;
            end
        end
        else if (accept && !in_bad)
        begin
            char_mem[in_idx] <= in_char;
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        clear_next  = clear_reg;
        report_next = report_reg;
        bad_next    = bad_reg;
        unique case (state_reg)
            S_LF_RD:
            begin
                state_next = S_LF_WR;
            end
            S_LF_WR:
            begin
                idx_next   = idx_reg - AW'(1);
                state_next = (idx_reg == LEAF0) ? S_INT_RD : S_LF_RD;
            end
            S_INT_RD:
            begin
                state_next = S_INT_WR;
            end
            S_INT_WR:
            begin
                if (idx_reg == ROOT)
                begin
                    clear_next = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg - AW'(1);
                    state_next = S_INT_RD;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    report_next = in_report;
                    bad_next    = in_bad;
                    idx_next    = ({1'b1, in_idx}) >> 1;
                    if (!in_bad)
                    begin
                        state_next = S_UP_RD;
                    end
                    else if (in_report)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_UP_RD:
            begin
                state_next = S_UP_WR;
            end
            S_UP_WR:
            begin
                if (idx_reg == ROOT)
                begin
                    state_next = report_reg ? S_FINISH : S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg >> 1;
                    state_next = S_UP_RD;
                end
            end
            S_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // a length change restarts the rebuild sweep
        if (cfg_we)
        begin
            state_next = S_LF_RD;
            idx_next   = TOP_NODE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LF_RD;
            idx_reg     <= TOP_NODE;
            clear_reg   <= 1'b1;
            report_reg  <= 1'b0;
            bad_reg     <= 1'b0;
            active_reg  <= ACTIVE_LENGTH_RESET;
            root_best_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            clear_reg  <= clear_next;
            report_reg <= report_next;
            bad_reg    <= bad_next;
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
            // keep the root best run at hand
            if ((state_reg == S_INT_WR || state_reg == S_UP_WR) && idx_reg == ROOT)
            begin
                root_best_reg <= merged[4*RW-1:3*RW];
            end
            // output register
            if (state_reg == S_FINISH && (!m_valid_reg || m_tready))
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign best_wide = {{LEN_W{1'b0}}, root_best_reg};

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FINISH && (!m_valid_reg || m_tready))
        begin
            m_run_reg <= best_wide[LEN_W-1:0];
            m_bad_reg <= bad_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(16-LEN_W){1'b0}}, m_run_reg};
    assign m_tuser  = m_bad_reg;

    // no request is taken while the store is being cleared
    a_no_accept_in_clear : assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !clear_reg)
        else $error("request taken during clearing pass");

    // tree walk never reaches node zero
    a_walk_index : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP_RD || state_reg == S_INT_RD) |-> (idx_reg != '0))
        else $error("tree walk left the tree");

    // a bad silent load completes at once
    a_bad_load_done : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_bad && !in_report && !cfg_we) |=> (state_reg == S_IDLE))
        else $error("bad silent load did not finish");

endmodule
`default_nettype wire
